@@ rtl/bccm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bccm_pkg
// Shared types and constants of the bounded coin change block.
// ----------------------------------------------------------------------------
package bccm_pkg;

  localparam int MAX_PRICE = 1023;
  localparam int DEPTH     = MAX_PRICE + 1;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int VAL_W     = 10;
  localparam int CNT_W     = 10;
  localparam int PRICE_W   = 10;
  localparam int COINS_W   = 10;
  localparam int ENTRY_W   = 11;
  localparam int CHUNK_W   = CNT_W + 1;
  localparam int STEP_W    = CNT_W + VAL_W;

  // largest value in an entry marks an amount that cannot be paid
  localparam logic [ENTRY_W-1:0] UNREACH   = {ENTRY_W{1'b1}};
  localparam logic [COINS_W-1:0] COINS_SAT = {COINS_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLAN,
    ST_SWEEP,
    ST_LOOKUP,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_en;
    logic plan;
    logic sweep_en;
    logic lookup;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic rem_zero;
    logic step_big;
    logic j_zero;
    logic j_last;
    logic wr_pend;
  } status_t;

endpackage

@@ rtl/bccm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bccm_ctrl
// Sequencer: table clear, per-chunk sweeps, price lookup and report.
// ----------------------------------------------------------------------------
module bccm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bccm_pkg::status_t sts,
  output bccm_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              report
);

  bccm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bccm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bccm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = bccm_pkg::ST_PLAN;
        end
      end
      bccm_pkg::ST_CLEAR: begin
        if (sts.j_zero) begin
          state_nxt = bccm_pkg::ST_PLAN;
        end
      end
      bccm_pkg::ST_PLAN: begin
        if (!sts.rem_zero) begin
          state_nxt = bccm_pkg::ST_SWEEP;
        end else if (sts.last) begin
          state_nxt = bccm_pkg::ST_LOOKUP;
        end else begin
          state_nxt = bccm_pkg::ST_IDLE;
        end
      end
      bccm_pkg::ST_SWEEP: begin
        if (sts.step_big || sts.j_last) begin
          state_nxt = bccm_pkg::ST_PLAN;
        end
      end
      bccm_pkg::ST_LOOKUP: state_nxt = bccm_pkg::ST_REPORT;
      bccm_pkg::ST_REPORT: state_nxt = bccm_pkg::ST_IDLE;
      default:             state_nxt = bccm_pkg::ST_IDLE;
    endcase
    // a first item clears the table before its sweeps
    if (state_r == bccm_pkg::ST_IDLE && start && sts.first) begin
      state_nxt = bccm_pkg::ST_CLEAR;
    end
  end

  // outputs
  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    report = 1'b0;
    case (state_r)
      bccm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bccm_pkg::ST_CLEAR:  cmd.clr_en   = 1'b1;
      bccm_pkg::ST_PLAN:   cmd.plan     = !sts.rem_zero;
      bccm_pkg::ST_SWEEP:  cmd.sweep_en = !sts.step_big;
      bccm_pkg::ST_LOOKUP: cmd.lookup   = 1'b1;
      bccm_pkg::ST_REPORT: report       = 1'b1;
      default:             busy         = 1'b1;
    endcase
  end

endmodule

@@ rtl/bccm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bccm_datapath
// Amount table memory, chunk planner and in-place 0/1 update pipeline.
// ----------------------------------------------------------------------------
module bccm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bccm_pkg::cmd_t                  cmd,
  input  logic [bccm_pkg::VAL_W-1:0]      in_coin_value,
  input  logic [bccm_pkg::CNT_W-1:0]      in_coin_count,
  input  logic                            in_first_kind,
  input  logic                            in_last_kind,
  input  logic [bccm_pkg::PRICE_W-1:0]    in_price,
  output bccm_pkg::status_t               sts,
  output logic                            out_payable,
  output logic [bccm_pkg::COINS_W-1:0]    out_min_coins
);

  logic [bccm_pkg::ENTRY_W-1:0] mem [0:bccm_pkg::DEPTH-1];

  logic [bccm_pkg::VAL_W-1:0]   value_r;
  logic [bccm_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [bccm_pkg::CHUNK_W-1:0] pow_r;
  logic [bccm_pkg::CNT_W-1:0]   chunk_r, chunk_nxt;
  logic [bccm_pkg::STEP_W-1:0]  step_r;
  logic                         last_r, price_ok_r;
  logic [bccm_pkg::ADDR_W-1:0]  price_addr_r;
  logic [bccm_pkg::ADDR_W-1:0]  j_r;

  logic [bccm_pkg::ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic [bccm_pkg::ENTRY_W-1:0] rd_a_r, rd_b_r;
  logic                         wr_vld_r;
  logic [bccm_pkg::ADDR_W-1:0]  wr_addr_r;

  logic [bccm_pkg::ENTRY_W-1:0] cand;
  logic                         improve;
  logic                         we;
  logic [bccm_pkg::ADDR_W-1:0]  waddr;
  logic [bccm_pkg::ENTRY_W-1:0] wdata;
  logic [bccm_pkg::CNT_W-1:0]   count_sat;
  logic                         payable;

  // count saturates at MAX_PRICE, a zero value contributes nothing
  always_comb begin
    if (32'(in_coin_count) > bccm_pkg::MAX_PRICE) begin
      count_sat = bccm_pkg::CNT_W'(bccm_pkg::MAX_PRICE);
    end else begin
      count_sat = in_coin_count;
    end
  end

  // binary split of the count: 1, 2, 4, ... then the remainder
  always_comb begin
    if ({1'b0, rem_r} < pow_r) begin
      chunk_nxt = rem_r;
    end else begin
      chunk_nxt = pow_r[bccm_pkg::CNT_W-1:0];
    end
    rem_nxt = rem_r - chunk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      last_r   <= 1'b0;
      pow_r    <= '0;
      j_r      <= bccm_pkg::ADDR_W'(bccm_pkg::MAX_PRICE);
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= cmd.sweep_en;
      if (cmd.load) begin
        rem_r   <= (in_coin_value == '0) ? '0 : count_sat;
        pow_r   <= bccm_pkg::CHUNK_W'(1);
        last_r  <= in_last_kind;
        j_r     <= bccm_pkg::ADDR_W'(bccm_pkg::MAX_PRICE);
      end else if (cmd.plan) begin
        rem_r <= rem_nxt;
        pow_r <= {pow_r[bccm_pkg::CHUNK_W-2:0], 1'b0};
        j_r   <= bccm_pkg::ADDR_W'(bccm_pkg::MAX_PRICE);
      end else if (cmd.clr_en || cmd.sweep_en) begin
        j_r <= j_r - bccm_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r      <= in_coin_value;
      price_ok_r   <= 32'(in_price) <= bccm_pkg::MAX_PRICE;
      price_addr_r <= bccm_pkg::ADDR_W'(in_price);
    end
    if (cmd.plan) begin
      chunk_r <= chunk_nxt;
      step_r  <= bccm_pkg::STEP_W'(chunk_nxt) * bccm_pkg::STEP_W'(value_r);
    end
    wr_addr_r <= j_r;
  end

  // reads: entry j and entry j - step, written back in descending order
  assign rd_addr_a = cmd.lookup ? price_addr_r : j_r;
  assign rd_addr_b = j_r - step_r[bccm_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign cand    = rd_b_r + bccm_pkg::ENTRY_W'(chunk_r);
  assign improve = (rd_b_r != bccm_pkg::UNREACH) && (cand < rd_a_r);

  always_comb begin
    we    = cmd.clr_en || (wr_vld_r && improve);
    waddr = cmd.clr_en ? j_r : wr_addr_r;
    if (cmd.clr_en) begin
      wdata = (j_r == '0) ? '0 : bccm_pkg::UNREACH;
    end else begin
      wdata = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign payable     = price_ok_r && (rd_a_r != bccm_pkg::UNREACH);
  assign out_payable = payable;
  always_comb begin
    if (!payable) begin
      out_min_coins = '0;
    end else if (rd_a_r > bccm_pkg::ENTRY_W'(bccm_pkg::COINS_SAT)) begin
      out_min_coins = bccm_pkg::COINS_SAT;
    end else begin
      out_min_coins = rd_a_r[bccm_pkg::COINS_W-1:0];
    end
  end

  // status to the sequencer; the first flag of the item on offer is seen while idle
  always_comb begin
    sts          = '0;
    sts.first    = in_first_kind;
    sts.last     = last_r;
    sts.rem_zero = (rem_r == '0);
    sts.step_big = (32'(step_r) > bccm_pkg::MAX_PRICE);
    sts.j_zero   = (j_r == '0);
    sts.j_last   = (bccm_pkg::STEP_W'(j_r) == step_r);
    sts.wr_pend  = wr_vld_r;
  end

endmodule

@@ rtl/bounded_coin_change_min_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_coin_change_min_top
// Fewest coins to pay a price with a bounded supply of each coin kind.
// ----------------------------------------------------------------------------
// Coin kinds are fed one item at a time on start while busy is low; the
// receiver cannot stall, so the single result of a last item appears on
// out_payable / out_min_coins for exactly one cycle with out_valid high.
// The count of each kind is split into chunks 1, 2, 4, ... plus a remainder,
// and each chunk is one descending in-place sweep over the amount table
// (one entry per cycle, set by the single write port of the table memory).
// An item runs: a clear of the whole amount table when first_kind is set, then
// per chunk a plan step and a sweep from MAX_PRICE down to chunk*value (no
// writes when chunk*value exceeds MAX_PRICE), then a final plan step, then
// lookup and report on a last item. After reset the table is cleared, with
// busy high.
// ----------------------------------------------------------------------------
module bounded_coin_change_min_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bccm_pkg::VAL_W-1:0]   in_coin_value,
  input  logic [bccm_pkg::CNT_W-1:0]   in_coin_count,
  input  logic                         in_first_kind,
  input  logic                         in_last_kind,
  input  logic [bccm_pkg::PRICE_W-1:0] in_price,
  output logic                         out_valid,
  output logic                         out_payable,
  output logic [bccm_pkg::COINS_W-1:0] out_min_coins
);

  // command and status between sequencer and datapath
  bccm_pkg::cmd_t    cmd;
  bccm_pkg::status_t sts;

  // sequencer: clear, chunk planning, sweeps, lookup, report
  bccm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .report (out_valid)
  );

  // table memory and update pipeline
  bccm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_coin_value (in_coin_value),
    .in_coin_count (in_coin_count),
    .in_first_kind (in_first_kind),
    .in_last_kind  (in_last_kind),
    .in_price      (in_price),
    .sts           (sts),
    .out_payable   (out_payable),
    .out_min_coins (out_min_coins)
  );

`ifndef SYNTHESIS
  // clearing never collides with a pending sweep write-back
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && sts.wr_pend))
    else $error("clear write during pending sweep write");

  // an accepted item keeps the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  // exactly one strobe per result
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // unpayable results report zero coins
  a_unpayable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payable) |-> (out_min_coins == '0))
    else $error("nonzero coin count on unpayable result");
`endif

endmodule
